/* design/qspr_pkg.sv */
// ----------------------------------------------------------------------------
// qspr_pkg
// shared types and constants for the queue based shortest path block
// ----------------------------------------------------------------------------
package qspr_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int MAX_EDGES   = 4096;
    localparam int WEIGHT_BITS = 16;

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int FILL_W  = $clog2(MAX_NODES + 1);
    localparam int ROW_W   = $clog2(MAX_NODES + 1);
    localparam int EADDR_W = $clog2(MAX_EDGES);
    localparam int ECNT_W  = 13;
    localparam int COST_W  = 32;

    localparam logic [COST_W-1:0] COST_INF = 32'hFFFF_FFFF;
    localparam logic [COST_W-1:0] COST_MAX = 32'hFFFF_FFFE;
    localparam logic [FILL_W-1:0] NODES_FULL = FILL_W'(MAX_NODES);
    localparam logic [ECNT_W-1:0] EDGES_END  = ECNT_W'(MAX_EDGES);

    localparam logic [1:0] CMD_OFFSET = 2'd0;
    localparam logic [1:0] CMD_EDGE   = 2'd1;
    localparam logic [1:0] CMD_RUN    = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [11:0] index;
        logic [12:0] offset_value;
        logic [9:0]  edge_target;
        logic [15:0] edge_weight;
        logic [9:0]  source_node;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [9:0]  node_id;
        logic [31:0] path_cost;
        logic        reachable;
    } out_item_t;

    typedef struct packed {
        logic [9:0]             target;
        logic [WEIGHT_BITS-1:0] weight;
    } edge_entry_t;

    typedef struct packed {
        logic              queued;
        logic [COST_W-1:0] cost;
    } node_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SEED,
        S_POP,
        S_POP_WAIT,
        S_ROW0,
        S_ROW1,
        S_ROW2,
        S_EDGE,
        S_EDGE_WAIT,
        S_NODE_WAIT,
        S_FINAL,
        S_FINAL_WAIT,
        S_READ_WAIT,
        S_RESULT
    } state_t;

    function automatic logic [ECNT_W-1:0] clamp_edge(input logic [ECNT_W-1:0] e);
        return (e > EDGES_END) ? EDGES_END : e;
    endfunction

endpackage

/* design/qspr_ram.sv */
// ----------------------------------------------------------------------------
// qspr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module qspr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/queue_shortest_path_relax.sv */
// ----------------------------------------------------------------------------
// queue_shortest_path_relax
// single source shortest paths over a compressed row graph with a work queue
// ----------------------------------------------------------------------------
// Offset and edge load items are handled in the idle state. A read item
// passes a wait state for its cost read unless the index is out of range or
// no run was made yet. A run item first sweeps the node cost memory, one entry
// a cycle, then per dequeued node the pop and row states, per out-edge the
// edge, edge wait and node wait states (no node wait for an unused node), as
// the edge and target cost fetches wait on registered reads before the update
// is written. Seeding and finishing add the seed, final and final wait states.
// Reads before the first run answer unreachable. Results wait in an output
// register so a new item is taken while a result is still pending.
module queue_shortest_path_relax
    import qspr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item,
    input  logic      cfg_we,
    input  logic [10:0] cfg_data
);

    state_t state_reg, state_next;

    logic [FILL_W-1:0] n_reg;
    logic              ran_reg, ran_next;
    logic [NODE_W-1:0] addr_reg, addr_next;
    logic [NODE_W-1:0] src_reg, src_next;
    logic [NODE_W-1:0] head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [COST_W-1:0] cur_cost_reg, cur_cost_next;
    logic [ECNT_W-1:0] start_reg, start_next;
    logic [ECNT_W-1:0] end_reg, end_next;
    logic [ECNT_W-1:0] edge_reg, edge_next;
    logic [NODE_W-1:0] nb_reg, nb_next;
    logic [COST_W-1:0] alt_reg, alt_next;
    out_item_t         res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    logic accept;
    logic out_free;
    logic [FILL_W-1:0] cfg_n;

    // memory ports
    logic               row_we;
    logic [ROW_W-1:0]   row_waddr, row_raddr;
    logic [12:0]        row_wdata, row_rdata;
    logic               edge_we;
    logic [EADDR_W-1:0] edge_waddr, edge_raddr;
    edge_entry_t        edge_wdata, edge_rdata;
    logic               node_we;
    logic [NODE_W-1:0]  node_waddr, node_raddr;
    node_entry_t        node_wdata, node_rdata;
    logic               fifo_we;
    logic [NODE_W-1:0]  fifo_waddr, fifo_raddr;
    logic [NODE_W-1:0]  fifo_wdata, fifo_rdata;

    logic [COST_W:0]    sum;

    qspr_ram #(.WIDTH(13), .DEPTH(MAX_NODES + 1)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    qspr_ram #(.WIDTH($bits(edge_entry_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    qspr_ram #(.WIDTH($bits(node_entry_t)), .DEPTH(MAX_NODES)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    qspr_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (fifo_wdata),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // clamp node count to 1..MAX_NODES
    always_comb
    begin
        if (cfg_data == 11'd0)
        begin
            cfg_n = FILL_W'(1);
        end
        else if (cfg_data > 11'(MAX_NODES))
        begin
            cfg_n = NODES_FULL;
        end
        else
        begin
            cfg_n = FILL_W'(cfg_data);
        end
    end

    assign sum = {1'b0, cur_cost_reg} + (COST_W + 1)'(edge_rdata.weight);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && in_item.command == CMD_RUN)
                begin
                    state_next = S_CLEAR;
                end
                else if (accept && in_item.command == CMD_READ)
                begin
                    if (in_item.index < 12'(n_reg) && ran_reg)
                    begin
                        state_next = S_READ_WAIT;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_CLEAR:
            begin
                if (addr_reg == NODE_W'(MAX_NODES - 1))
                begin
                    state_next = ({1'b0, src_reg} < n_reg) ? S_SEED : S_RESULT;
                end
            end
            S_SEED:      state_next = S_POP;
            S_POP:       state_next = (fill_reg == '0) ? S_FINAL : S_POP_WAIT;
            S_POP_WAIT:  state_next = S_ROW0;
            S_ROW0:      state_next = S_ROW1;
            S_ROW1:      state_next = S_ROW2;
            S_ROW2:      state_next = S_EDGE;
            S_EDGE:      state_next = (edge_reg >= end_reg) ? S_POP : S_EDGE_WAIT;
            S_EDGE_WAIT:
            begin
                state_next = ({1'b0, edge_rdata.target} < n_reg) ? S_NODE_WAIT : S_EDGE;
            end
            S_NODE_WAIT:  state_next = S_EDGE;
            S_FINAL:      state_next = S_FINAL_WAIT;
            S_FINAL_WAIT: state_next = S_RESULT;
            S_READ_WAIT:  state_next = S_RESULT;
            S_RESULT:     state_next = out_free ? S_IDLE : S_RESULT;
            default:      state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        ran_next       = ran_reg;
        addr_next      = addr_reg;
        src_next       = src_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        cur_next       = cur_reg;
        cur_cost_next  = cur_cost_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        edge_next      = edge_reg;
        nb_next        = nb_reg;
        alt_next       = alt_reg;
        res_next       = res_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && out_stall;

        row_we     = 1'b0;
        row_waddr  = in_item.index[ROW_W-1:0];
        row_wdata  = in_item.offset_value;
        row_raddr  = {1'b0, cur_reg};
        edge_we    = 1'b0;
        edge_waddr = in_item.index[EADDR_W-1:0];
        edge_wdata = '{target: in_item.edge_target,
                       weight: in_item.edge_weight[WEIGHT_BITS-1:0]};
        edge_raddr = edge_reg[EADDR_W-1:0];
        node_we    = 1'b0;
        node_waddr = addr_reg;
        node_wdata = '{queued: 1'b0, cost: COST_INF};
        node_raddr = cur_reg;
        fifo_we    = 1'b0;
        fifo_waddr = head_reg + fill_reg[NODE_W-1:0];
        fifo_wdata = nb_reg;
        fifo_raddr = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_item.command)
                        CMD_OFFSET:
                        begin
                            row_we = (in_item.index <= 12'(MAX_NODES));
                        end
                        CMD_EDGE:
                        begin
                            edge_we = 1'b1;
                        end
                        CMD_RUN:
                        begin
                            src_next  = in_item.source_node;
                            addr_next = '0;
                            ran_next  = 1'b1;
                            res_next  = '{kind: KIND_DONE, node_id: in_item.source_node,
                                          path_cost: COST_INF, reachable: 1'b0};
                        end
                        default:
                        begin
                            node_raddr = in_item.index[NODE_W-1:0];
                            res_next   = '{kind: KIND_READ, node_id: in_item.index[9:0],
                                           path_cost: COST_INF, reachable: 1'b0};
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                node_we   = 1'b1;
                addr_next = addr_reg + 1'b1;
            end
            S_SEED:
            begin
                node_we    = 1'b1;
                node_waddr = src_reg;
                node_wdata = '{queued: 1'b1, cost: '0};
                fifo_we    = 1'b1;
                fifo_waddr = '0;
                fifo_wdata = src_reg;
                head_next  = '0;
                fill_next  = FILL_W'(1);
            end
            S_POP:
            begin
                if (fill_reg != '0)
                begin
                    head_next = head_reg + 1'b1;
                    fill_next = fill_reg - 1'b1;
                end
            end
            S_POP_WAIT:
            begin
                cur_next = fifo_rdata;
            end
            S_ROW0:
            begin
                row_raddr  = {1'b0, cur_reg};
                node_raddr = cur_reg;
            end
            S_ROW1:
            begin
                start_next    = clamp_edge(row_rdata);
                cur_cost_next = node_rdata.cost;
                node_we       = 1'b1;
                node_waddr    = cur_reg;
                node_wdata    = '{queued: 1'b0, cost: node_rdata.cost};
                row_raddr     = ROW_W'(cur_reg) + 1'b1;
            end
            S_ROW2:
            begin
                end_next  = clamp_edge(row_rdata);
                edge_next = start_reg;
            end
            S_EDGE:
            begin
                edge_raddr = edge_reg[EADDR_W-1:0];
            end
            S_EDGE_WAIT:
            begin
                nb_next    = edge_rdata.target;
                node_raddr = edge_rdata.target;
                alt_next   = (sum > {1'b0, COST_MAX}) ? COST_MAX : sum[COST_W-1:0];
                if ({1'b0, edge_rdata.target} >= n_reg)
                begin
                    edge_next = edge_reg + 1'b1;
                end
            end
            S_NODE_WAIT:
            begin
                edge_next = edge_reg + 1'b1;
                if (node_rdata.cost > alt_reg)
                begin
                    node_we    = 1'b1;
                    node_waddr = nb_reg;
                    node_wdata = '{queued: 1'b1, cost: alt_reg};
                    if (!node_rdata.queued && fill_reg < NODES_FULL)
                    begin
                        fifo_we   = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            S_FINAL:
            begin
                node_raddr = src_reg;
            end
            S_FINAL_WAIT, S_READ_WAIT:
            begin
                res_next.path_cost = node_rdata.cost;
                res_next.reachable = (node_rdata.cost != COST_INF);
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= NODES_FULL;
            ran_reg       <= 1'b0;
            head_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ran_reg       <= ran_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                n_reg <= cfg_n;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        src_reg      <= src_next;
        cur_reg      <= cur_next;
        cur_cost_reg <= cur_cost_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
        edge_reg     <= edge_next;
        nb_reg       <= nb_next;
        alt_reg      <= alt_next;
        res_reg      <= res_next;
        out_item_reg <= out_item_next;
    end

endmodule

/* verif/qspr_checker.sv */
// ----------------------------------------------------------------------------
// qspr_checker
// watches the item channels, predicts shortest path costs and compares results
// ----------------------------------------------------------------------------
module qspr_checker
    import qspr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_item,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_item,
    input  logic      cfg_we,
    input  logic [10:0] cfg_data,
    output int        fail_count,
    output int        pending_count
);

    logic [12:0] row_tab [0:MAX_NODES];
    logic [9:0]  tgt_tab [0:MAX_EDGES-1];
    logic [15:0] wgt_tab [0:MAX_EDGES-1];
    logic [31:0] cost_tab [0:MAX_NODES-1];
    logic        in_queue [0:MAX_NODES-1];
    logic [10:0] node_cfg;
    out_item_t   expected_q [$];

    function automatic int nodes_in_use();
        if (node_cfg == 0) return 1;
        if (node_cfg > MAX_NODES) return MAX_NODES;
        return node_cfg;
    endfunction

    function automatic int edge_bound(logic [12:0] e);
        return (e > MAX_EDGES) ? MAX_EDGES : e;
    endfunction

    task automatic relax_from(int src, int n);
        int work [$];
        int cur, lo, hi, nb;
        logic [32:0] sum;
        logic [31:0] alt;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            cost_tab[i] = COST_INF;
            in_queue[i] = 1'b0;
        end
        if (src >= n) return;
        cost_tab[src] = 0;
        in_queue[src] = 1'b1;
        work.push_back(src);
        while (work.size() != 0)
        begin
            cur = work.pop_front();
            in_queue[cur] = 1'b0;
            lo = edge_bound(row_tab[cur]);
            hi = edge_bound(row_tab[cur+1]);
            for (int e = lo; e < hi; e++)
            begin
                nb = tgt_tab[e];
                if (nb >= n) continue;
                sum = {1'b0, cost_tab[cur]} + wgt_tab[e];
                alt = (sum > COST_MAX) ? COST_MAX : sum[31:0];
                if (cost_tab[nb] > alt)
                begin
                    cost_tab[nb] = alt;
                    if (!in_queue[nb])
                    begin
                        in_queue[nb] = 1'b1;
                        work.push_back(nb);
                    end
                end
            end
        end
    endtask

    task automatic predict(in_item_t it);
        out_item_t r;
        int n;
        n = nodes_in_use();
        case (it.command)
            CMD_OFFSET:
                if (it.index <= MAX_NODES) row_tab[it.index] = it.offset_value;
            CMD_EDGE:
                if (it.index < MAX_EDGES)
                begin
                    tgt_tab[it.index] = it.edge_target;
                    wgt_tab[it.index] = it.edge_weight;
                end
            CMD_RUN:
            begin
                relax_from(it.source_node, n);
                r.kind = KIND_DONE;
                r.node_id = it.source_node;
                r.path_cost = (it.source_node < n) ? cost_tab[it.source_node] : COST_INF;
                r.reachable = (r.path_cost != COST_INF);
                expected_q.push_back(r);
            end
            default:
            begin
                r.kind = KIND_READ;
                r.node_id = it.index[9:0];
                r.path_cost = (it.index < n) ? cost_tab[it.index] : COST_INF;
                r.reachable = (r.path_cost != COST_INF);
                expected_q.push_back(r);
            end
        endcase
    endtask

    initial
    begin
        fail_count = 0;
        pending_count = 0;
        node_cfg = 11'd1024;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            cost_tab[i] = COST_INF;
            in_queue[i] = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (cfg_we) node_cfg = cfg_data;
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result item %p", out_item);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_item.kind !== want.kind)
                    begin
                        $error("kind exp %0d got %0d", want.kind, out_item.kind);
                        fail_count++;
                    end
                    if (out_item.node_id !== want.node_id)
                    begin
                        $error("node_id exp %0d got %0d", want.node_id, out_item.node_id);
                        fail_count++;
                    end
                    if (out_item.path_cost !== want.path_cost)
                    begin
                        $error("path_cost exp %0h got %0h", want.path_cost,
                               out_item.path_cost);
                        fail_count++;
                    end
                    if (out_item.reachable !== want.reachable)
                    begin
                        $error("reachable exp %0d got %0d", want.reachable,
                               out_item.reachable);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall) predict(in_item);
            pending_count = expected_q.size();
        end
    end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// random graph loads, runs and reads against the shortest path block
// ----------------------------------------------------------------------------
module tb_top;
    import qspr_pkg::*;

    localparam int WATCHDOG = 1000000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;
    logic      cfg_we;
    logic [10:0] cfg_data;
    int        fail_count;
    int        pending_count;
    int        idle_cycles;
    bit        calm;
    int        sent;
    int        graph_nodes;

    queue_shortest_path_relax u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    qspr_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog on accepted traffic
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("queue_shortest_path_relax verification failed");
            $finish;
        end
    end

    // receiver stall bursts
    initial
    begin
        int len;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                len = $urandom_range(1, 6);
                out_stall <= 1'b1;
                repeat (len) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // valid stays high after an item until the next item or a drain
    task automatic send(in_item_t it);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    function automatic in_item_t noise_fields();
        logic [63:0] raw;
        in_item_t it;
        raw = {$urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        return it;
    endfunction

    task automatic put_offset(int node, int value);
        in_item_t it;
        it = noise_fields();
        it.command = CMD_OFFSET;
        it.index = 12'(node);
        it.offset_value = 13'(value);
        send(it);
    endtask

    task automatic put_edge(int idx, int tgt, int w);
        in_item_t it;
        it = noise_fields();
        it.command = CMD_EDGE;
        it.index = 12'(idx);
        it.edge_target = 10'(tgt);
        it.edge_weight = 16'(w);
        send(it);
    endtask

    task automatic put_run(int src);
        in_item_t it;
        it = noise_fields();
        it.command = CMD_RUN;
        it.source_node = 10'(src);
        send(it);
    endtask

    task automatic put_read(int node);
        in_item_t it;
        it = noise_fields();
        it.command = CMD_READ;
        it.index = 12'(node);
        send(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_nodes(int value);
        drain();
        cfg_data <= 11'(value);
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // random graph over the first nodes, rows in order, few edges per node
    // the two nodes past the graph get empty rows since edges may reach them
    task automatic load_graph(int nodes, int max_deg, int wmode);
        int e;
        int w;
        e = $urandom_range(0, 3);
        for (int v = 0; v <= nodes + 2; v++)
        begin
            put_offset(v, e);
            if (v >= nodes) continue;
            for (int k = $urandom_range(0, max_deg); k > 0; k--)
            begin
                case (wmode)
                    0: w = $urandom_range(0, 20);
                    1: w = $urandom_range(65500, 65535);
                    default: w = $urandom & 16'hFFFF;
                endcase
                put_edge(e, $urandom_range(0, nodes + 1), w);
                e++;
            end
        end
    endtask

    // heavy chain of maximum weights over the first nodes
    task automatic saturation_chain();
        for (int v = 0; v < 4; v++) put_offset(v, v);
        put_offset(4, 3);
        for (int e = 0; e < 3; e++) put_edge(e, e + 1, 16'hFFFF);
    endtask

    initial
    begin
        in_item_t it;
        int pick;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        calm = 0;
        sent = 0;
        idle_cycles = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        put_read(0);
        put_read(4095);
        put_offset(0, 0);
        put_offset(1, 2);
        put_offset(2, 3);
        put_offset(3, 8191);
        put_offset(4, 4096);
        put_offset(1023, 3);
        put_offset(1024, 3);
        put_offset(4096, 5);
        put_edge(0, 1, 0);
        put_edge(1, 1023, 65535);
        put_edge(2, 3, 65535);
        put_edge(4095, 2, 65535);
        put_edge(4095, 1, 7);
        put_run(0);
        put_read(1);
        put_read(1023);
        put_run(1023);
        set_nodes(2);
        put_run(5);
        put_read(3);
        put_run(0);
        put_read(1);
        drain();

        set_nodes(0);
        put_run(0);
        put_read(0);
        set_nodes(2047);
        put_run(1);
        put_read(2);

        // random phases
        while (sent < 650)
        begin
            graph_nodes = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(2, 12);
            set_nodes(($urandom_range(0, 7) == 0) ? 1024 : graph_nodes);
            load_graph(graph_nodes, $urandom_range(0, 4), $urandom_range(0, 2));
            if ($urandom_range(0, 5) == 0) saturation_chain();
            for (int k = $urandom_range(2, 5); k > 0; k--)
            begin
                put_run($urandom_range(0, graph_nodes));
                for (int r = $urandom_range(1, 6); r > 0; r--)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0) put_read($urandom & 12'hFFF);
                    else put_read($urandom_range(0, graph_nodes));
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    it = noise_fields();
                    if (it.command == CMD_OFFSET && it.index <= MAX_NODES) it.index = 12'hFFF;
                    if (it.command == CMD_EDGE && it.index < MAX_EDGES) it.index = 12'hFFF;
                    if (it.command == CMD_RUN) it.command = CMD_READ;
                    send(it);
                end
            end
            if (sent > 550) calm = 1;
        end

        drain();
        if (fail_count == 0)
            $display("queue_shortest_path_relax verification clean");
        else
            $display("queue_shortest_path_relax verification failed");
        $finish;
    end

endmodule
